FILE: design/gcsld_pkg.sv
`default_nettype none
package gcsld_pkg;

	localparam int CAM_PIXELS_DEF  = 65536;
	localparam int PROJ_WIDTH_DEF  = 1024;
	localparam int PROJ_HEIGHT_DEF = 768;

	localparam int ADDR_W     = 16;
	localparam int PLANE_W    = 5;
	localparam int LEVEL_W    = 8;
	localparam int THR_W      = 9;
	localparam int COORD_W    = 10;
	// Widest Gray part: a projector side of up to 4096 pixels needs 13 bits.
	localparam int GRAY_MAX_W = 13;

	typedef struct packed {
		logic [ADDR_W-1:0]     pixel;
		logic [GRAY_MAX_W-1:0] col_gray;
		logic [GRAY_MAX_W-1:0] row_gray;
	} code_t;

endpackage
`default_nettype wire

FILE: design/gcsld_in_if.sv
`default_nettype none
interface gcsld_in_if;
	logic                          valid;
	logic                          ready;
	logic [gcsld_pkg::ADDR_W-1:0]  pixel_addr;
	logic [gcsld_pkg::PLANE_W-1:0] plane;
	logic [gcsld_pkg::LEVEL_W-1:0] posi_level;
	logic [gcsld_pkg::LEVEL_W-1:0] nega_level;

	modport source(output valid, pixel_addr, plane, posi_level, nega_level, input ready);
	modport sink(input valid, pixel_addr, plane, posi_level, nega_level, output ready);
endinterface
`default_nettype wire

FILE: design/gcsld_out_if.sv
`default_nettype none
interface gcsld_out_if;
	logic                          valid;
	logic                          ready;
	logic [gcsld_pkg::ADDR_W-1:0]  out_pixel;
	logic                          match_valid;
	logic [gcsld_pkg::COORD_W-1:0] proj_x;
	logic [gcsld_pkg::COORD_W-1:0] proj_y;

	modport source(output valid, out_pixel, match_valid, proj_x, proj_y, input ready);
	modport sink(input valid, out_pixel, match_valid, proj_x, proj_y, output ready);
endinterface
`default_nettype wire

FILE: design/gcsld_cfg_if.sv
`default_nettype none
interface gcsld_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [gcsld_pkg::THR_W-1:0] bit_threshold;

	modport source(output valid, bit_threshold, input ready);
	modport sink(input valid, bit_threshold, output ready);
endinterface
`default_nettype wire

FILE: design/gcsld_store.sv
`default_nettype none
module gcsld_store #(
	parameter int CAM_PIXELS  = gcsld_pkg::CAM_PIXELS_DEF,
	parameter int PROJ_WIDTH  = gcsld_pkg::PROJ_WIDTH_DEF,
	parameter int PROJ_HEIGHT = gcsld_pkg::PROJ_HEIGHT_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [gcsld_pkg::THR_W-1:0] bit_threshold,
	gcsld_in_if.sink                         pixels,
	output logic                             code_valid,
	input  wire logic                        code_ready,
	output gcsld_pkg::code_t                 code
);

	localparam int W_BITS    = $clog2(PROJ_WIDTH + 1);
	localparam int H_BITS    = $clog2(PROJ_HEIGHT + 1);
	localparam int ALL_BITS  = W_BITS + H_BITS;
	localparam int BP_W      = $clog2(ALL_BITS);
	localparam int MEM_DEPTH = (CAM_PIXELS > 65536) ? 65536 : CAM_PIXELS;
	localparam int IDX_W     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	logic [ALL_BITS-1:0] mem [MEM_DEPTH];

	logic                en;
	logic                in_acc;
	logic                in_range;
	logic [IDX_W-1:0]    in_idx;
	logic                in_one;
	logic signed [9:0]   diff;
	logic signed [9:0]   thr_ext;

	logic                s1_valid;
	logic [IDX_W-1:0]    s1_idx;
	logic [15:0]         s1_pixel;
	logic [BP_W-1:0]     s1_bitpos;
	logic                s1_first;
	logic                s1_last;
	logic                s1_one;
	logic [ALL_BITS-1:0] rd_q;
	logic                fwd_hit_q;
	logic [ALL_BITS-1:0] fwd_word_q;

	logic [ALL_BITS-1:0] base_word;
	logic [ALL_BITS-1:0] mask;
	logic [ALL_BITS-1:0] new_word;
	logic                wr_en;

	logic                s2_valid;
	gcsld_pkg::code_t    code_s2;

	assign en           = !s2_valid || code_ready;
	assign pixels.ready = en;
	assign in_acc       = pixels.valid && en;
	assign in_range     = (32'(pixels.pixel_addr) < 32'(CAM_PIXELS)) &&
	                      ({1'b0, pixels.plane} < 6'(ALL_BITS));
	assign in_idx       = pixels.pixel_addr[IDX_W-1:0];
	assign diff         = signed'({2'b00, pixels.posi_level}) - signed'({2'b00, pixels.nega_level});
	assign thr_ext      = signed'({bit_threshold[8], bit_threshold});
	assign in_one       = diff >= thr_ext;

	assign base_word = fwd_hit_q ? fwd_word_q : rd_q;
	assign mask      = ALL_BITS'(1) << s1_bitpos;
	assign new_word  = s1_first ? (s1_one ? mask : '0)
	                            : ((base_word & ~mask) | (s1_one ? mask : '0));
	assign wr_en     = s1_valid && en;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			rd_q <= mem[in_idx];
		end
		if (wr_en) begin
			mem[s1_idx] <= new_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid  <= 1'b0;
			fwd_hit_q <= 1'b0;
			s2_valid  <= 1'b0;
		end else if (en) begin
			s1_valid  <= in_acc && in_range;
			fwd_hit_q <= wr_en && in_acc && in_range && (in_idx == s1_idx);
			s2_valid  <= s1_valid && s1_last;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s1_idx     <= in_idx;
			s1_pixel   <= pixels.pixel_addr;
			s1_bitpos  <= BP_W'(ALL_BITS - 1) - BP_W'(pixels.plane);
			s1_first   <= pixels.plane == '0;
			s1_last    <= {1'b0, pixels.plane} == 6'(ALL_BITS - 1);
			s1_one     <= in_one;
			fwd_word_q <= new_word;
			code_s2.pixel    <= s1_pixel;
			code_s2.col_gray <= gcsld_pkg::GRAY_MAX_W'(new_word[W_BITS-1:0]);
			code_s2.row_gray <= gcsld_pkg::GRAY_MAX_W'(new_word[ALL_BITS-1:W_BITS]);
		end
	end

	assign code_valid = s2_valid;
	assign code       = code_s2;

	a_fwd_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_hit_q |-> s1_valid)
		else $error("Forwarded word flagged without an item in the first stage.");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_range |=> s1_valid)
		else $error("An accepted in-range transaction did not enter the first stage.");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid && !en |=> s1_valid && $stable(s1_idx) && $stable(s1_bitpos))
		else $error("The first stage changed while stalled.");

endmodule
`default_nettype wire

FILE: design/gcsld_decode.sv
`default_nettype none
module gcsld_decode #(
	parameter int PROJ_WIDTH  = gcsld_pkg::PROJ_WIDTH_DEF,
	parameter int PROJ_HEIGHT = gcsld_pkg::PROJ_HEIGHT_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         code_valid,
	output logic              code_ready,
	input  gcsld_pkg::code_t  code,
	gcsld_out_if.source       coords
);

	localparam int GW = gcsld_pkg::GRAY_MAX_W;

	function automatic logic [GW-1:0] gray_to_bin(input logic [GW-1:0] g);
		logic [GW-1:0] b;
		for (int i = 0; i < GW; i++) begin
			b[i] = ^(g >> i);
		end
		return b;
	endfunction

	logic [GW-1:0] bx;
	logic [GW-1:0] by;
	logic          hit;
	logic          out_valid_q;
	logic [15:0]   pixel_q;
	logic          match_q;
	logic [9:0]    x_q;
	logic [9:0]    y_q;

	assign bx  = gray_to_bin(code.col_gray);
	assign by  = gray_to_bin(code.row_gray);
	assign hit = (bx != '0) && (bx <= GW'(PROJ_WIDTH)) &&
	             (by != '0) && (by <= GW'(PROJ_HEIGHT));

	assign code_ready = !out_valid_q || coords.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (code_ready) begin
			out_valid_q <= code_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (code_ready && code_valid) begin
			pixel_q <= code.pixel;
			match_q <= hit;
			x_q     <= hit ? 10'(bx - GW'(1)) : '0;
			y_q     <= hit ? 10'(by - GW'(1)) : '0;
		end
	end

	assign coords.valid       = out_valid_q;
	assign coords.out_pixel   = pixel_q;
	assign coords.match_valid = match_q;
	assign coords.proj_x      = x_q;
	assign coords.proj_y      = y_q;

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !match_q |-> x_q == '0 && y_q == '0)
		else $error("An invalid match carries a non-zero coordinate.");

endmodule
`default_nettype wire

FILE: design/gray_code_structured_light_decoder_top.sv
`default_nettype none
// Decodes streamed Gray code bit planes into projector coordinates, taking one pixel
// transaction per clock unless the output stalls, also when consecutive transactions
// hit the same pixel. Code words live in one synchronous memory, read on acceptance and
// written back from the first stage; the last write is forwarded to the next. A pixel's
// last plane yields its result via the first stage, code register and output register.
// The memory starts undefined and is never cleared: plane 0 of each pixel must arrive
// before its other planes, and the block is ready straight after reset.
module gray_code_structured_light_decoder_top #(
	parameter int CAM_PIXELS  = gcsld_pkg::CAM_PIXELS_DEF,
	parameter int PROJ_WIDTH  = gcsld_pkg::PROJ_WIDTH_DEF,
	parameter int PROJ_HEIGHT = gcsld_pkg::PROJ_HEIGHT_DEF
) (
	input wire logic     clk,
	input wire logic     arst_n,
	gcsld_cfg_if.sink    cfg,
	gcsld_in_if.sink     pixels,
	gcsld_out_if.source  coords
);

	logic [gcsld_pkg::THR_W-1:0] threshold_q;
	logic                        code_valid;
	logic                        code_ready;
	gcsld_pkg::code_t            code;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= '0;
		end else if (cfg.valid) begin
			threshold_q <= cfg.bit_threshold;
		end
	end

	gcsld_store #(
		.CAM_PIXELS (CAM_PIXELS),
		.PROJ_WIDTH (PROJ_WIDTH),
		.PROJ_HEIGHT(PROJ_HEIGHT)
	) u_store (
		.clk          (clk),
		.arst_n       (arst_n),
		.bit_threshold(threshold_q),
		.pixels       (pixels),
		.code_valid   (code_valid),
		.code_ready   (code_ready),
		.code         (code)
	);

	gcsld_decode #(
		.PROJ_WIDTH (PROJ_WIDTH),
		.PROJ_HEIGHT(PROJ_HEIGHT)
	) u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.code_valid(code_valid),
		.code_ready(code_ready),
		.code      (code),
		.coords    (coords)
	);

endmodule
`default_nettype wire
